// ===== sv/sorf_pkg.sv =====
// Shared types and constants for the scan obstacle range finder.
// Depends on nothing; used by all modules.
`default_nettype none

package sorf_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CfgFrontXMin  = 3'd0,
    CfgFrontXMax  = 3'd1,
    CfgFrontYHalf = 3'd2,
    CfgSideXMin   = 3'd3,
    CfgSideXMax   = 3'd4,
    CfgSideYHalf  = 3'd5,
    CfgTurnRadius = 3'd6,
    CfgBlindZone  = 3'd7
  } cfg_idx_e;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int LenW     = 15;
  localparam int R2W      = 2 * LenW;

  // Reset values
  localparam logic signed [15:0] FrontXMinRst  = 16'sd300;
  localparam logic signed [15:0] FrontXMaxRst  = 16'sd2300;
  localparam logic [LenW-1:0]    FrontYHalfRst = 15'd300;
  localparam logic signed [15:0] SideXMinRst   = 16'sd500;
  localparam logic signed [15:0] SideXMaxRst   = 16'sd2000;
  localparam logic [LenW-1:0]    SideYHalfRst  = 15'd1000;
  localparam logic [LenW-1:0]    TurnRadiusRst = 15'd1000;
  localparam logic [LenW-1:0]    BlindZoneRst  = 15'd100;
  localparam logic [R2W-1:0]     TurnR2Rst     = 30'd1000000;

  // Depth of the queue between front and back
  localparam int QueueDepth = 4;

  // Live configuration, with the squared radius kept alongside
  typedef struct packed {
    logic signed [15:0] front_x_min;
    logic signed [15:0] front_x_max;
    logic [LenW-1:0]    front_y_half;
    logic signed [15:0] side_x_min;
    logic signed [15:0] side_x_max;
    logic [LenW-1:0]    side_y_half;
    logic [R2W-1:0]     turn_r2;
    logic [LenW-1:0]    blind_zone;
  } cfg_t;

  // Back end status toward the queue and the top level
  typedef struct packed {
    logic pop;
    logic pop_last;
  } back_sts_t;

endpackage

`default_nettype wire

// ===== sv/sorf_if.sv =====
// Point and result channel interfaces for the scan obstacle range finder.
// No dependencies.
`default_nettype none

interface sorf_point_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface sorf_result_if;
  logic               valid;
  logic               ready;
  logic               front_found;
  logic signed [15:0] front_nearest_x;
  logic               left_found;
  logic [15:0]        left_nearest;
  logic               right_found;
  logic [15:0]        right_nearest;

  modport source (output valid, front_found, front_nearest_x, left_found, left_nearest,
                  right_found, right_nearest, input ready);
  modport sink   (input valid, front_found, front_nearest_x, left_found, left_nearest,
                  right_found, right_nearest, output ready);
endinterface

`default_nettype wire

// ===== sv/sorf_front.sv =====
// Front end: accepts points, classifies them against both boxes, squares |x| and |y|.
// Depends on sorf_pkg and sorf_point_if.
`default_nettype none

module sorf_front #(
  parameter int COORD_BITS = 16,
  parameter int EntryW     = 6 * COORD_BITS + 5
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sorf_pkg::cfg_t     cfg_i,
  sorf_point_if.sink              point_i,
  input  wire logic               q_full_i,
  output logic                    q_push_o,
  output logic [EntryW-1:0]       q_data_o
);
  import sorf_pkg::*;

  localparam int CmpW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 1;
  localparam int SqW  = 2 * COORD_BITS;

  typedef struct packed {
    logic                  last;
    logic                  front_in;
    logic                  side_in;
    logic                  y_neg;
    logic                  y_pos;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] ay;
    logic [SqW-1:0]        ax2;
    logic [SqW-1:0]        ay2;
  } entry_t;

  logic                  vld_q, vld_d;
  entry_t                ent_q, ent_d;
  logic                  take;
  logic [COORD_BITS-1:0] ax, ay;
  logic signed [CmpW-1:0] xs;
  logic [CmpW-1:0]       ay_w;

  // Stage register moves on when the queue has room
  assign q_push_o      = vld_q && !q_full_i;
  assign point_i.ready = !vld_q || !q_full_i;
  assign take          = point_i.valid && point_i.ready;
  assign q_data_o      = ent_q;

  // Classification and squares
  always_comb begin
    ax   = point_i.point_x[COORD_BITS-1] ? COORD_BITS'(-point_i.point_x)
                                         : COORD_BITS'(point_i.point_x);
    ay   = point_i.point_y[COORD_BITS-1] ? COORD_BITS'(-point_i.point_y)
                                         : COORD_BITS'(point_i.point_y);
    xs   = CmpW'(point_i.point_x);
    ay_w = CmpW'(ay);

    ent_d          = ent_q;
    ent_d.last     = point_i.last_point;
    ent_d.front_in = (xs >= CmpW'(cfg_i.front_x_min)) && (xs <= CmpW'(cfg_i.front_x_max)) &&
                     (ay_w <= CmpW'(cfg_i.front_y_half));
    ent_d.side_in  = (xs >= CmpW'(cfg_i.side_x_min)) && (xs <= CmpW'(cfg_i.side_x_max)) &&
                     (ay_w <= CmpW'(cfg_i.side_y_half));
    ent_d.y_neg    = point_i.point_y[COORD_BITS-1];
    ent_d.y_pos    = !point_i.point_y[COORD_BITS-1] && (point_i.point_y != '0);
    ent_d.x        = point_i.point_x;
    ent_d.ay       = ay;
    ent_d.ax2      = SqW'(ax) * SqW'(ax);
    ent_d.ay2      = SqW'(ay) * SqW'(ay);
  end

  assign vld_d = take ? 1'b1 : (q_push_o ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload holds while stalled
  always_ff @(posedge clk_i) begin
    if (take) begin
      ent_q <= ent_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sorf_queue.sv =====
// Short FIFO between the front and back ends.
// Depends on sorf_pkg for its depth and the back end status type.
`default_nettype none

module sorf_queue #(
  parameter int EntryW = 101
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [EntryW-1:0] data_i,
  output logic                   full_o,
  input  wire sorf_pkg::back_sts_t sts_i,
  output logic                   vld_o,
  output logic [EntryW-1:0]      data_o
);
  import sorf_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  logic [EntryW-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o = (cnt_q == CntW'(QueueDepth));
  assign vld_o  = (cnt_q != '0);
  assign data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = sts_i.pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(push_i) - CntW'(sts_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sorf_back.sv =====
// Back end: radius test, running minima per scan, and the result register.
// Depends on sorf_pkg and sorf_result_if.
`default_nettype none

module sorf_back #(
  parameter int COORD_BITS = 16,
  parameter int EntryW     = 6 * COORD_BITS + 5
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sorf_pkg::cfg_t     cfg_i,
  input  wire logic               q_vld_i,
  input  wire logic [EntryW-1:0]  q_data_i,
  output sorf_pkg::back_sts_t     sts_o,
  sorf_result_if.source           result_o
);
  import sorf_pkg::*;

  localparam int CmpW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 1;
  localparam int SqW  = 2 * COORD_BITS;
  localparam int SumW = ((SqW + 1) > R2W) ? (SqW + 1) : R2W;

  typedef struct packed {
    logic                  last;
    logic                  front_in;
    logic                  side_in;
    logic                  y_neg;
    logic                  y_pos;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] ay;
    logic [SqW-1:0]        ax2;
    logic [SqW-1:0]        ay2;
  } entry_t;

  entry_t                 ent;
  logic [SumW-1:0]        d2;
  logic                   qual;
  logic                   pop, pop_last;
  logic                   out_vld_q, out_vld_d;

  logic                   fh_q, fh_d, lh_q, lh_d, rh_q, rh_d;
  logic [COORD_BITS-1:0]  fm_q, fm_d, lm_q, lm_d, rm_q, rm_d;
  logic                   fh_n, lh_n, rh_n;
  logic [COORD_BITS-1:0]  fm_n, lm_n, rm_n;
  logic signed [CmpW-1:0] fm_w;

  assign ent = entry_t'(q_data_i);

  // A non-final point never waits; a final one needs the result register free
  assign pop          = q_vld_i && (!ent.last || !out_vld_q || result_o.ready);
  assign pop_last     = pop && ent.last;
  assign sts_o.pop      = pop;
  assign sts_o.pop_last = pop_last;

  assign d2   = SumW'(ent.ax2) + SumW'(ent.ay2);
  assign qual = ent.side_in && (d2 < SumW'(cfg_i.turn_r2));

  // Minima after this point
  always_comb begin
    fh_n = fh_q;  fm_n = fm_q;
    lh_n = lh_q;  lm_n = lm_q;
    rh_n = rh_q;  rm_n = rm_q;

    if (ent.front_in) begin
      if (!fh_q || ($signed(ent.x) < $signed(fm_q))) begin
        fm_n = ent.x;
      end
      fh_n = 1'b1;
    end

    if (qual && ent.y_neg) begin
      if (!rh_q) begin
        rh_n = 1'b1;
        rm_n = ent.ay;
      end else if ((ent.ay < rm_q) && (CmpW'(ent.ay) > CmpW'(cfg_i.blind_zone))) begin
        rm_n = ent.ay;
      end
    end

    if (qual && ent.y_pos) begin
      if (!lh_q) begin
        lh_n = 1'b1;
        lm_n = ent.ay;
      end else if ((ent.ay < lm_q) && (CmpW'(ent.ay) > CmpW'(cfg_i.blind_zone))) begin
        lm_n = ent.ay;
      end
    end
  end

  // State: held when idle, cleared at the end of a scan
  always_comb begin
    fh_d = fh_q;  fm_d = fm_q;
    lh_d = lh_q;  lm_d = lm_q;
    rh_d = rh_q;  rm_d = rm_q;
    if (pop_last) begin
      fh_d = 1'b0;  fm_d = '0;
      lh_d = 1'b0;  lm_d = '0;
      rh_d = 1'b0;  rm_d = '0;
    end else if (pop) begin
      fh_d = fh_n;  fm_d = fm_n;
      lh_d = lh_n;  lm_d = lm_n;
      rh_d = rh_n;  rm_d = rm_n;
    end
  end

  assign out_vld_d = pop_last ? 1'b1 : (result_o.ready ? 1'b0 : out_vld_q);
  assign fm_w      = CmpW'($signed(fm_n));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fh_q      <= 1'b0;
      fm_q      <= '0;
      lh_q      <= 1'b0;
      lm_q      <= '0;
      rh_q      <= 1'b0;
      rm_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      fh_q      <= fh_d;
      fm_q      <= fm_d;
      lh_q      <= lh_d;
      lm_q      <= lm_d;
      rh_q      <= rh_d;
      rm_q      <= rm_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (pop_last) begin
      result_o.front_found     <= fh_n;
      result_o.front_nearest_x <= fh_n ? fm_w[15:0] : 16'sd0;
      result_o.left_found      <= lh_n;
      result_o.left_nearest    <= lh_n ? 16'(CmpW'(lm_n)) : 16'd0;
      result_o.right_found     <= rh_n;
      result_o.right_nearest   <= rh_n ? 16'(CmpW'(rm_n)) : 16'd0;
    end
  end

  assign result_o.valid = out_vld_q;

endmodule

`default_nettype wire

// ===== sv/scan_obstacle_range_finder.sv =====
// Scan obstacle range finder, top level.
// Throughput: one point per cycle while the queue has room; the front stage, queue and back end
// each move 1/cycle, but a final point waits in the queue while the result register is held.
// Path: a final point passes the front register and the queue write; the result register loads
// as the entry pops, and that waits only while the result channel stalls.
// Reset: asynchronous, active low; clears all per-scan state, the queue and restores the
// configuration defaults. Depends on sorf_pkg, sorf_if, sorf_front, sorf_queue, sorf_back.
`default_nettype none

module scan_obstacle_range_finder #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [sorf_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [sorf_pkg::CfgDataW-1:0]     cfg_wdata_i,
  sorf_point_if.sink                             point_i,
  sorf_result_if.source                          result_o
);
  import sorf_pkg::*;

  localparam int EntryW = 6 * COORD_BITS + 5;

  cfg_t              cfg_q, cfg_d;
  logic              q_push, q_full, q_vld;
  logic [EntryW-1:0] q_wdata, q_rdata;
  back_sts_t         back_sts;

  // Configuration writes; the squared radius is formed at write time
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgFrontXMin:  cfg_d.front_x_min  = cfg_wdata_i;
        CfgFrontXMax:  cfg_d.front_x_max  = cfg_wdata_i;
        CfgFrontYHalf: cfg_d.front_y_half = cfg_wdata_i[LenW-1:0];
        CfgSideXMin:   cfg_d.side_x_min   = cfg_wdata_i;
        CfgSideXMax:   cfg_d.side_x_max   = cfg_wdata_i;
        CfgSideYHalf:  cfg_d.side_y_half  = cfg_wdata_i[LenW-1:0];
        CfgTurnRadius: cfg_d.turn_r2      = R2W'(cfg_wdata_i[LenW-1:0]) *
                                            R2W'(cfg_wdata_i[LenW-1:0]);
        CfgBlindZone:  cfg_d.blind_zone   = cfg_wdata_i[LenW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.front_x_min  <= FrontXMinRst;
      cfg_q.front_x_max  <= FrontXMaxRst;
      cfg_q.front_y_half <= FrontYHalfRst;
      cfg_q.side_x_min   <= SideXMinRst;
      cfg_q.side_x_max   <= SideXMaxRst;
      cfg_q.side_y_half  <= SideYHalfRst;
      cfg_q.turn_r2      <= TurnR2Rst;
      cfg_q.blind_zone   <= BlindZoneRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sorf_front #(
    .COORD_BITS (COORD_BITS),
    .EntryW     (EntryW)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .point_i  (point_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  sorf_queue #(
    .EntryW (EntryW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .sts_i  (back_sts),
    .vld_o  (q_vld),
    .data_o (q_rdata)
  );

  sorf_back #(
    .COORD_BITS (COORD_BITS),
    .EntryW     (EntryW)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .q_vld_i  (q_vld),
    .q_data_i (q_rdata),
    .sts_o    (back_sts),
    .result_o (result_o)
  );

  // A scan end always shows up as a result in the next cycle
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_sts.pop_last |=> result_o.valid)
    else $error("final point popped without a result");

  // A taken result with no new scan end leaves the channel empty
  a_result_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.ready && !back_sts.pop_last) |=> !result_o.valid)
    else $error("result repeated after its transaction");

  // The back end never pops from an empty queue
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_sts.pop |-> q_vld)
    else $error("queue underflow");

  // Missing sides report a zero distance; this check covers the left side
  a_zero_when_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.left_found) |-> (result_o.left_nearest == 16'd0))
    else $error("left distance set without a hit");

endmodule

`default_nettype wire
